[rtl/core/pta_pkg.sv]
// ----------------------------------------------------------------------------
// pta_pkg: shared types and constants for the pixel tone adjust core
// Register indexes, lane control and config structs, and the gamma lookup
// table, which is built at elaboration by exact integer comparison.
// ----------------------------------------------------------------------------
package pta_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_STRETCH_ENABLE    = 3'd0,
    REG_BLACK_LEVEL       = 3'd1,
    REG_STRETCH_GAIN      = 3'd2,
    REG_CONTRAST_GAIN     = 3'd3,
    REG_BRIGHTNESS_OFFSET = 3'd4,
    REG_GAMMA_TENTHS      = 3'd5
  } cfg_reg_t;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  // Gamma range, in tenths
  localparam logic [4:0] GAMMA_MIN   = 5'd5;
  localparam logic [4:0] GAMMA_MAX   = 5'd20;
  localparam logic [4:0] GAMMA_UNITY = 5'd10;
  localparam int GAMMA_ROWS = 16;
  localparam int LEVELS     = 256;
  localparam int ROM_DEPTH  = GAMMA_ROWS * LEVELS;

  // Per-lane register enables, one per lane pipeline stage
  typedef struct packed {
    logic stretch;
    logic contrast;
    logic clamp;
    logic gamma;
  } lane_en_t;

  // Register settings as seen by the lanes
  typedef struct packed {
    logic               stretch_enable;
    logic [7:0]         black_level;
    logic [15:0]        stretch_gain;
    logic signed [11:0] contrast_gain;
    logic signed [9:0]  brightness_offset;
    logic [3:0]         gamma_row;
    logic               gamma_bypass;
  } tone_cfg_t;

  typedef logic [ROM_DEPTH-1:0][7:0] gamma_rom_t;

  // Wide enough for 255^20
  localparam int BIG_W = 168;

  function automatic logic [BIG_W-1:0] big_pow(int unsigned base, int unsigned e);
    logic [BIG_W-1:0] acc;
    acc = BIG_W'(1);
    for (int unsigned i = 0; i < e; i++) begin
      acc = acc * BIG_W'(base);
    end
    return acc;
  endfunction

  // rom[g-5][v] = floor(255 * (v/255)^(10/g)): largest y with
  // y^g * 255^(10-g) <= v^10 * 255^(g-10)
  function automatic gamma_rom_t build_gamma_rom();
    gamma_rom_t       rom;
    logic [BIG_W-1:0] rhs;
    logic [BIG_W-1:0] lhs;
    int unsigned      g;
    int unsigned      y;
    logic             fits;
    rom = '0;
    for (int unsigned gi = 0; gi < GAMMA_ROWS; gi++) begin
      g = gi + 32'(GAMMA_MIN);
      y = 0;
      for (int unsigned v = 0; v < LEVELS; v++) begin
        rhs = big_pow(v, 32'(GAMMA_UNITY));
        if (g > 32'(GAMMA_UNITY)) rhs = rhs * big_pow(255, g - 32'(GAMMA_UNITY));
        fits = 1'b1;
        while (fits && y < 255) begin
          lhs = big_pow(y + 1, g);
          if (g < 32'(GAMMA_UNITY)) lhs = lhs * big_pow(255, 32'(GAMMA_UNITY) - g);
          fits = (lhs <= rhs);
          if (fits) y = y + 1;
        end
        rom[gi * LEVELS + v] = 8'(y);
      end
    end
    return rom;
  endfunction

  localparam gamma_rom_t GAMMA_ROM = build_gamma_rom();

endpackage

[rtl/core/pixel_tone_adjust_rgb565_core.sv]
// ----------------------------------------------------------------------------
// pixel_tone_adjust_rgb565_core: brightness, contrast and gamma to RGB565
// Three channel lanes run side by side; a merge stage packs their results.
//
//   channel   direction  signals                        payload
//   s_*       in         s_tvalid s_tready s_tdata[39:0] red, green, blue
//   m_*       out        m_tvalid m_tready m_tdata[15:0] pixel_565
//   cfg_*     in         cfg_valid cfg_ready             cfg_index, cfg_data
//
// One pixel per clock sustained while m_tready is high; the stages are stretch,
// contrast, clamp, gamma table and the pack/output register.
// Each stage loads when it is empty or the stage after it moves, so bubbles
// close up and input is still taken while a result waits at the output.
// rst is synchronous: clears the stage valid bits and restores register
// defaults. cfg_ready is always high.
// ----------------------------------------------------------------------------
module pixel_tone_adjust_rgb565_core (
  input  logic                               clk,
  input  logic                               rst,
  // red_in [10:0], green_in [21:11], blue_in [32:22], zero [39:33]
  input  logic [39:0]                        s_tdata,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // pixel_565 [15:0]
  output logic [15:0]                        m_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [pta_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [pta_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import pta_pkg::*;

  localparam int STAGES = 5;

  logic                      stretch_enable;
  logic [7:0]                black_level;
  logic [15:0]               stretch_gain;
  logic signed [11:0]        contrast_gain;
  logic signed [9:0]         brightness_offset;
  logic [4:0]                gamma_tenths;
  logic [4:0]                gamma_clamped;
  tone_cfg_t                 cfg;
  logic [STAGES-1:0]         stage_valid;
  logic [STAGES-1:0]         stage_en;
  lane_en_t                  lane_en;
  logic [7:0]                red_val;
  logic [7:0]                green_val;
  logic [7:0]                blue_val;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      stretch_enable    <= 1'b0;
      black_level       <= 8'd0;
      stretch_gain      <= 16'd256;
      contrast_gain     <= 12'sd256;
      brightness_offset <= 10'sd0;
      gamma_tenths      <= GAMMA_UNITY;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_STRETCH_ENABLE:    stretch_enable    <= cfg_data[0];
        REG_BLACK_LEVEL:       black_level       <= cfg_data[7:0];
        REG_STRETCH_GAIN:      stretch_gain      <= cfg_data;
        REG_CONTRAST_GAIN:     contrast_gain     <= cfg_data[11:0];
        REG_BRIGHTNESS_OFFSET: brightness_offset <= cfg_data[9:0];
        REG_GAMMA_TENTHS:      gamma_tenths      <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // Gamma setting held to its range; unity bypasses the table
  always_comb begin
    priority if (gamma_tenths < GAMMA_MIN) begin
      gamma_clamped = GAMMA_MIN;
    end else if (gamma_tenths > GAMMA_MAX) begin
      gamma_clamped = GAMMA_MAX;
    end else begin
      gamma_clamped = gamma_tenths;
    end
  end

  always_comb begin
    cfg.stretch_enable    = stretch_enable;
    cfg.black_level       = black_level;
    cfg.stretch_gain      = stretch_gain;
    cfg.contrast_gain     = contrast_gain;
    cfg.brightness_offset = brightness_offset;
    cfg.gamma_row         = 4'(gamma_clamped - GAMMA_MIN);
    cfg.gamma_bypass      = (gamma_clamped == GAMMA_UNITY);
  end

  // Stage enables: a stage moves when empty or when its successor moves
  always_comb begin
    stage_en[STAGES-1] = !stage_valid[STAGES-1] || m_tready;
    for (int k = STAGES - 2; k >= 0; k--) begin
      stage_en[k] = !stage_valid[k] || stage_en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      if (stage_en[0]) stage_valid[0] <= s_tvalid;
      for (int k = 1; k < STAGES; k++) begin
        if (stage_en[k]) stage_valid[k] <= stage_valid[k-1];
      end
    end
  end

  assign lane_en.stretch  = stage_en[0];
  assign lane_en.contrast = stage_en[1];
  assign lane_en.clamp    = stage_en[2];
  assign lane_en.gamma    = stage_en[3];

  assign s_tready = stage_en[0];
  assign m_tvalid = stage_valid[STAGES-1];

  // Channel lanes
  pta_lane u_lane_red (
    .clk      (clk),
    .chan_in  (s_tdata[10:0]),
    .cfg      (cfg),
    .en       (lane_en),
    .chan_out (red_val)
  );

  pta_lane u_lane_green (
    .clk      (clk),
    .chan_in  (s_tdata[21:11]),
    .cfg      (cfg),
    .en       (lane_en),
    .chan_out (green_val)
  );

  pta_lane u_lane_blue (
    .clk      (clk),
    .chan_in  (s_tdata[32:22]),
    .cfg      (cfg),
    .en       (lane_en),
    .chan_out (blue_val)
  );

  // Pack and output register
  pta_merge u_merge (
    .clk   (clk),
    .en    (stage_en[STAGES-1]),
    .red   (red_val),
    .green (green_val),
    .blue  (blue_val),
    .pixel (m_tdata)
  );

endmodule

[rtl/core/pta_lane.sv]
// ----------------------------------------------------------------------------
// pta_lane: one color channel of the tone adjust pipeline
// Stretch, contrast and brightness, saturation, then gamma lookup; four
// register stages, each loaded by its own enable.
// ----------------------------------------------------------------------------
module pta_lane (
  input  logic                clk,
  input  logic signed [10:0]  chan_in,
  input  pta_pkg::tone_cfg_t  cfg,
  input  pta_pkg::lane_en_t   en,
  output logic [7:0]          chan_out
);
  import pta_pkg::*;

  logic signed [11:0] diff;
  logic signed [28:0] sprod;
  logic signed [28:0] sadj;
  logic signed [19:0] stretched;
  logic signed [19:0] s1;
  logic signed [20:0] centered;
  logic signed [32:0] cprod;
  logic signed [32:0] cprod_q;
  logic signed [32:0] cadj;
  logic signed [24:0] ctrunc;
  logic signed [25:0] level;
  logic [7:0]         clamped;
  logic [7:0]         clamped_q;
  logic [11:0]        rom_addr;
  logic [7:0]         curve_val;

  // Stage 1: levels stretch, product truncated toward zero
  assign diff  = {chan_in[10], chan_in} - $signed({4'b0, cfg.black_level});
  assign sprod = diff * $signed({1'b0, cfg.stretch_gain});
  assign sadj  = sprod + (sprod[28] ? 29'sd255 : 29'sd0);
  assign stretched = cfg.stretch_enable ? sadj[27:8] : 20'(chan_in);

  always_ff @(posedge clk) begin
    if (en.stretch) s1 <= stretched;
  end

  // Stage 2: contrast product about mid gray
  assign centered = 21'(s1) - 21'sd128;
  assign cprod    = centered * cfg.contrast_gain;

  always_ff @(posedge clk) begin
    if (en.contrast) cprod_q <= cprod;
  end

  // Stage 3: truncate, re-center, add brightness, saturate to 0..255
  assign cadj   = cprod_q + (cprod_q[32] ? 33'sd255 : 33'sd0);
  assign ctrunc = cadj[32:8];
  assign level  = 26'(ctrunc) + 26'sd128 + 26'(cfg.brightness_offset);

  always_comb begin
    priority if (level < 26'sd0) begin
      clamped = 8'd0;
    end else if (level > 26'sd255) begin
      clamped = 8'd255;
    end else begin
      clamped = level[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en.clamp) clamped_q <= clamped;
  end

  // Stage 4: gamma table, row picked by the gamma setting
  assign rom_addr  = {cfg.gamma_row, clamped_q};
  assign curve_val = cfg.gamma_bypass ? clamped_q : GAMMA_ROM[rom_addr];

  always_ff @(posedge clk) begin
    if (en.gamma) chan_out <= curve_val;
  end

endmodule

[rtl/core/pta_merge.sv]
// ----------------------------------------------------------------------------
// pta_merge: combines the three lane results into one RGB565 word
// Keeps the top 5/6/5 bits of each channel and holds them in the output
// register.
// ----------------------------------------------------------------------------
module pta_merge (
  input  logic        clk,
  input  logic        en,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  output logic [15:0] pixel
);

  // Pack red 15..11, green 10..5, blue 4..0
  always_ff @(posedge clk) begin
    if (en) pixel <= {red[7:3], green[7:2], blue[7:3]};
  end

endmodule

[tb/pixel_tone_adjust_rgb565_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_tone_adjust_rgb565_core_tb: self-checking regression for the tone core
// Streams signed RGB pixels through the core under a series of register
// settings, predicts each RGB565 word from a local model of the stretch,
// contrast, clamp and gamma steps, and compares the words in order. Both
// stream sides idle at random in most segments; settings change only with the pipe drained.
// ----------------------------------------------------------------------------
module pixel_tone_adjust_rgb565_core_tb;

  import pta_pkg::*;

  localparam int          WATCHDOG_LIMIT = 1000;
  localparam int          DRAIN_CYCLES   = 8;
  localparam int          BATCH_PIXELS   = 120;
  localparam int          NUM_SEGMENTS   = 15;
  // register slots past the end of the map; writes to them are dropped
  localparam logic [2:0]  REG_SPARE_LO   = 3'd6;
  localparam logic [2:0]  REG_SPARE_HI   = 3'd7;

  // red in the low bits, matching the s_tdata layout
  typedef struct packed {
    logic signed [10:0] blue;
    logic signed [10:0] green;
    logic signed [10:0] red;
  } pixel_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  // red_in [10:0], green_in [21:11], blue_in [32:22], zero [39:33]
  logic [39:0] s_tdata = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  // pixel_565 [15:0]
  logic [15:0] m_tdata;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  pixel_tone_adjust_rgb565_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial forever #10 clk = ~clk;

  // Local copy of the register file
  logic               lvl_stretch_en;
  logic [7:0]         lvl_black;
  logic [15:0]        lvl_gain;
  logic signed [11:0] con_gain;
  logic signed [9:0]  bright_off;
  logic [4:0]         gamma_setting;

  logic [7:0]  tone_lut [16][256];
  pixel_t      pending_pixels [$];
  logic [15:0] expected_565 [$];
  pixel_t      next_pixel;
  logic        s_taken = 1'b0;
  logic [15:0] want_565;
  int          send_idle_pct = 18;
  int          recv_stall_pct = 63;
  int          mismatch_count = 0;
  int          quiet_cycles = 0;

  function automatic logic [175:0] wide_pow(int unsigned base, int unsigned e);
    logic [175:0] acc;
    acc = 176'd1;
    repeat (e) acc = acc * base;
    return acc;
  endfunction

  // lut[g-5][v] = floor(255 * (v/255)^(10/g)), by exact integer comparison:
  // y fits when y^g * 255^(10-g) <= v^10 * 255^(g-10)
  function automatic void build_tone_lut();
    int unsigned  g;
    int unsigned  y;
    logic [175:0] bound;
    logic [175:0] probe;
    logic         fits;
    for (int gi = 0; gi < 16; gi++) begin
      g = gi + 5;
      y = 0;
      for (int v = 0; v < 256; v++) begin
        bound = wide_pow(v, 10) * wide_pow(255, (g > 10) ? g - 10 : 0);
        fits = 1'b1;
        while (fits && y < 255) begin
          probe = wide_pow(y + 1, g) * wide_pow(255, (g < 10) ? 10 - g : 0);
          fits = (probe <= bound);
          if (fits) y++;
        end
        tone_lut[gi][v] = 8'(y);
      end
    end
  endfunction

  // One channel: stretch, contrast and brightness, clamp, gamma
  function automatic logic [7:0] predict_channel(logic signed [10:0] raw);
    longint      v;
    int unsigned g;
    v = raw;
    // integer division truncates toward zero, as the datapath does
    if (lvl_stretch_en) v = ((v - longint'(lvl_black)) * longint'(lvl_gain)) / 256;
    v = ((v - 128) * longint'(con_gain)) / 256 + 128 + longint'(bright_off);
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    g = gamma_setting;
    if (g < GAMMA_MIN) g = GAMMA_MIN;
    if (g > GAMMA_MAX) g = GAMMA_MAX;
    if (g != GAMMA_UNITY) v = tone_lut[g - GAMMA_MIN][v[7:0]];
    return v[7:0];
  endfunction

  function automatic logic [15:0] predict_pixel_565(logic signed [10:0] r,
                                                    logic signed [10:0] g,
                                                    logic signed [10:0] b);
    logic [7:0] rc;
    logic [7:0] gc;
    logic [7:0] bc;
    rc = predict_channel(r);
    gc = predict_channel(g);
    bc = predict_channel(b);
    return {rc[7:3], gc[7:2], bc[7:3]};
  endfunction

  // Pixel source: new transaction only once the last one was taken
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_taken) begin
      if (pending_pixels.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_pixel = pending_pixels.pop_front();
        s_tdata  <= {7'd0, next_pixel};
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Monitor: register model, prediction, compare, watchdog
  always @(posedge clk) begin
    if (rst) begin
      lvl_stretch_en = 1'b0;
      lvl_black      = 8'd0;
      lvl_gain       = 16'd256;
      con_gain       = 12'sd256;
      bright_off     = 10'sd0;
      gamma_setting  = GAMMA_UNITY;
      s_taken       <= 1'b0;
      quiet_cycles   = 0;
    end else begin
      s_taken <= s_tvalid && s_tready;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_STRETCH_ENABLE:    lvl_stretch_en = cfg_data[0];
          REG_BLACK_LEVEL:       lvl_black      = cfg_data[7:0];
          REG_STRETCH_GAIN:      lvl_gain       = cfg_data;
          REG_CONTRAST_GAIN:     con_gain       = cfg_data[11:0];
          REG_BRIGHTNESS_OFFSET: bright_off     = cfg_data[9:0];
          REG_GAMMA_TENTHS:      gamma_setting  = cfg_data[4:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready)
        expected_565.push_back(predict_pixel_565(s_tdata[10:0], s_tdata[21:11],
                                                 s_tdata[32:22]));
      if (m_tvalid && m_tready) begin
        if (expected_565.size() == 0) begin
          $display("%0t: unexpected pixel transaction, expected none, got %h",
                   $time, m_tdata);
          mismatch_count++;
        end else begin
          want_565 = expected_565.pop_front();
          if (m_tdata !== want_565) begin
            $display("%0t: pixel_565 mismatch, expected %h, got %h",
                     $time, want_565, m_tdata);
            mismatch_count++;
          end
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
        $display("pixel_tone_adjust_rgb565_core regression: fail");
        $finish;
      end
    end
  end

  // Register write; bits above the register width carry junk
  task automatic write_reg(logic [2:0] idx, int value, int width);
    logic [15:0] mask;
    mask = 16'((32'd1 << width) - 1);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data  <= (16'($urandom) & ~mask) | (16'(value) & mask);
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_settings(int se, int bl, int sg, int cg, int bo, int gt);
    write_reg(REG_STRETCH_ENABLE, se, 1);
    write_reg(REG_BLACK_LEVEL, bl, 8);
    write_reg(REG_STRETCH_GAIN, sg, 16);
    write_reg(REG_CONTRAST_GAIN, cg, 12);
    write_reg(REG_BRIGHTNESS_OFFSET, bo, 10);
    write_reg(REG_GAMMA_TENTHS, gt, 5);
  endtask

  task automatic push_pixel(int r, int g, int b);
    pixel_t p;
    p.red   = 11'(r);
    p.green = 11'(g);
    p.blue  = 11'(b);
    pending_pixels.push_back(p);
  endtask

  // Mostly in-range levels, some overshoot across the full signed span
  function automatic int rand_level();
    case ($urandom_range(9))
      7:       return int'($urandom_range(2047)) - 1024;
      8:       return int'($urandom_range(300)) - 22;
      9: begin
        case ($urandom_range(3))
          0:       return -1024;
          1:       return 1023;
          2:       return 0;
          default: return 255;
        endcase
      end
      default: return int'($urandom_range(255));
    endcase
  endfunction

  // Field extremes and the points around the contrast midpoint
  task automatic push_corner_pixels();
    push_pixel(-1024, -1024, -1024);
    push_pixel(1023, 1023, 1023);
    push_pixel(0, 127, 128);
    push_pixel(255, 256, -1);
    push_pixel(129, -129, 511);
    push_pixel(-512, 64, 200);
  endtask

  task automatic push_random_pixels(int count);
    repeat (count) push_pixel(rand_level(), rand_level(), rand_level());
  endtask

  // Sender holds off until every predicted word has come back; checked at
  // the rising edge, where the source queue and s_tvalid are settled
  task automatic wait_drained();
    @(posedge clk);
    while (pending_pixels.size() != 0 || expected_565.size() != 0 || s_tvalid)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin
    int sg;
    int cg;
    int bo;
    int gt;
    build_tone_lut();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset settings: identity transfer for in-range levels
    @(posedge clk);
    push_corner_pixels();
    push_random_pixels(60);
    wait_drained();

    for (int seg = 0; seg < NUM_SEGMENTS; seg++) begin
      if (seg < 5) begin
        send_idle_pct = 18;
        recv_stall_pct = 63;
      end else if (seg < 10) begin
        send_idle_pct = 63;
        recv_stall_pct = 18;
      end else begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      sg = ($urandom_range(3) == 0) ? int'($urandom_range(65535))
                                    : 65280 / int'($urandom_range(1, 255));
      cg = $urandom_range(1) ? int'($urandom_range(96, 640))
                             : int'($urandom_range(4095)) - 2048;
      bo = ($urandom_range(2) != 0) ? int'($urandom_range(128)) - 64
                                    : int'($urandom_range(1023)) - 512;
      gt = ($urandom_range(4) == 0) ? int'($urandom_range(31))
                                    : int'($urandom_range(5, 20));
      case (seg)
        // all registers at one end of their range
        0: write_settings(1, 255, 65535, -2048, -512, 5);
        // zero stretch gain, other end of the ranges
        1: write_settings(1, 0, 0, 2047, 511, 20);
        // gamma below its range; spare slots must not disturb anything
        2: begin
          write_settings($urandom_range(1), $urandom_range(255), sg, cg, bo, 0);
          write_reg(REG_SPARE_LO, $urandom, 16);
          write_reg(REG_SPARE_HI, $urandom, 16);
        end
        // gamma above its range
        3: write_settings(0, $urandom_range(255), sg, cg, bo, 31);
        // flat contrast: output set by brightness alone
        4: write_settings(1, $urandom_range(255), sg, 0, bo, GAMMA_UNITY);
        default: write_settings($urandom_range(1), $urandom_range(255), sg, cg, bo, gt);
      endcase
      @(posedge clk);
      if (seg < 2) push_corner_pixels();
      push_random_pixels(BATCH_PIXELS);
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("pixel_tone_adjust_rgb565_core regression: pass");
    else
      $display("pixel_tone_adjust_rgb565_core regression: fail");
    $finish;
  end

endmodule
